### rtl/ccfr_pkg.sv
// Shared types, codes and the CRC-32 byte step for the CRC checked frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ccfr_pkg;

  localparam int unsigned CntW = 16;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  // Register indexes of the configuration port.
  localparam logic REG_EXPECTED_LENGTH     = 1'b0;
  localparam logic REG_WRITE_FUNCTION_CODE = 1'b1;

  // Result status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_LEN_BAD  = 3'd1;
  localparam logic [2:0] STAT_FUNC_BAD = 3'd2;
  localparam logic [2:0] STAT_CRC_BAD  = 3'd3;
  localparam logic [2:0] STAT_CUT      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_PAYLOAD,
    ST_CRC,
    ST_EMIT
  } ccfr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       frame_start;
    logic       hdr_byte;
    logic       pay_byte;
    logic       crc_byte;
    logic       cnt_clr;
    logic       load_err;
    logic [2:0] err_code;
    logic       load_cmd;
    logic       load_data;
  } ccfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       out_free;
    logic       hdr_last;
    logic       pay_last;
    logic       crc_last;
    logic       len_zero;
    logic       emit_last;
    logic [2:0] verdict;
  } ccfr_sts_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/ccfr_ctrl.sv
// Frame receiver controller: tracks the frame phase and sequences the result beats.
// Depends on ccfr_pkg; drives the command struct of ccfr_dp.
`timescale 1ns / 1ps

module ccfr_ctrl import ccfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      frame_start_i,
  output logic      in_stall_o,
  input  ccfr_sts_t sts_i,
  output ccfr_cmd_t cmd_o
);

  ccfr_state_e state_q, state_d;
  logic        acc;

  assign in_stall_o = (state_q == ST_EMIT) || !sts_i.out_free;
  assign acc        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    if (acc && frame_start_i) begin
      state_d = ST_HEADER;
    end else if (acc) begin
      unique case (state_q)
        ST_HEADER: begin
          if (sts_i.hdr_last) state_d = sts_i.len_zero ? ST_CRC : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          if (sts_i.pay_last) state_d = ST_CRC;
        end
        ST_CRC: begin
          if (sts_i.crc_last) begin
            state_d = (sts_i.verdict == STAT_OK && !sts_i.len_zero) ? ST_EMIT : ST_IDLE;
          end
        end
        ST_IDLE, ST_EMIT: state_d = state_q;
        default: state_d = ST_IDLE;
      endcase
    end else if (state_q == ST_EMIT && sts_i.out_free && sts_i.emit_last) begin
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.err_code = STAT_OK;
    if (acc && frame_start_i) begin
      cmd_o.frame_start = 1'b1;
      if (state_q != ST_IDLE) begin
        cmd_o.load_err = 1'b1;
        cmd_o.err_code = STAT_CUT;
      end
    end else if (acc) begin
      unique case (state_q)
        ST_HEADER: begin
          cmd_o.hdr_byte = 1'b1;
          cmd_o.cnt_clr  = sts_i.hdr_last;
        end
        ST_PAYLOAD: begin
          cmd_o.pay_byte = 1'b1;
          cmd_o.cnt_clr  = sts_i.pay_last;
        end
        ST_CRC: begin
          cmd_o.crc_byte = 1'b1;
          if (sts_i.crc_last) begin
            if (sts_i.verdict != STAT_OK) begin
              cmd_o.load_err = 1'b1;
              cmd_o.err_code = sts_i.verdict;
            end else begin
              cmd_o.load_cmd = 1'b1;
              cmd_o.cnt_clr  = 1'b1;
            end
          end
        end
        ST_IDLE, ST_EMIT: ;
        default: ;
      endcase
    end else if (state_q == ST_EMIT && sts_i.out_free) begin
      cmd_o.load_data = 1'b1;
    end
  end

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_err, cmd_o.load_cmd, cmd_o.load_data}))
    else $error("more than one result beat loaded in a cycle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_err || cmd_o.load_cmd || cmd_o.load_data) |-> sts_i.out_free)
    else $error("result beat loaded over an undelivered one");

  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && $past(state_q) != ST_EMIT) |-> $past(cmd_o.load_cmd))
    else $error("payload burst started without a command beat");

  a_emit_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_EMIT && $past(state_q) == ST_EMIT) |->
      $past(cmd_o.load_data && sts_i.emit_last))
    else $error("payload burst ended before its last beat");

endmodule

### rtl/ccfr_dp.sv
// Frame receiver datapath: header fields, CRC, byte counter, payload memory and
// the result register. Depends on ccfr_pkg; controlled by ccfr_ctrl.
`timescale 1ns / 1ps

module ccfr_dp import ccfr_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic [5:0] expected_length_i,
  input  logic [7:0] write_function_code_i,
  input  ccfr_cmd_t  cmd_i,
  output ccfr_sts_t  sts_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] out_byte_o,
  output logic       is_command_o,
  output logic       last_o
);

  localparam int unsigned AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW:0]   cnt_inc;
  logic [7:0]      func_q, func_d;
  logic [CntW-1:0] len_q, len_d;
  logic [7:0]      command_q, command_d;
  logic [31:0]     crc_q, crc_d, crc_src, crc_upd;
  logic [31:0]     rcv_q, rcv_d;
  logic [CntW-1:0] need;
  logic            len_bad, func_bad, crc_bad;

  logic [7:0]      mem [PAYLOAD_MAX];
  logic [7:0]      rd_q;
  logic [AW-1:0]   rd_addr;

  logic            out_vld_q, out_vld_d;
  logic [2:0]      out_status_q;
  logic [7:0]      out_byte_q;
  logic            out_iscmd_q, out_last_q;

  assign cnt_inc = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};
  assign crc_src = cmd_i.frame_start ? CRC_PRESET : crc_q;
  assign crc_upd = crc32_byte(crc_src, rx_byte_i);

  // The judgment uses the fourth CRC byte straight from the input.
  assign need     = (command_q == 8'h00) ? {{(CntW-6){1'b0}}, expected_length_i} : '0;
  assign len_bad  = (len_q != need) || (len_q > CntW'(PAYLOAD_MAX));
  assign func_bad = (func_q != write_function_code_i);
  assign crc_bad  = (~crc_q) != {rx_byte_i, rcv_q[23:0]};

  always_comb begin
    sts_o           = '0;
    sts_o.out_free  = !out_vld_q || !out_stall_i;
    sts_o.hdr_last  = (cnt_q[1:0] == 2'd3);
    sts_o.pay_last  = (cnt_inc == {1'b0, len_q});
    sts_o.crc_last  = (cnt_q[1:0] == 2'd3);
    sts_o.len_zero  = (len_q == '0);
    sts_o.emit_last = (cnt_inc == {1'b0, len_q});
    priority if (len_bad) sts_o.verdict = STAT_LEN_BAD;
    else if (func_bad)    sts_o.verdict = STAT_FUNC_BAD;
    else if (crc_bad)     sts_o.verdict = STAT_CRC_BAD;
    else                  sts_o.verdict = STAT_OK;
  end

  always_comb begin
    cnt_d     = cnt_q;
    func_d    = func_q;
    len_d     = len_q;
    command_d = command_q;
    crc_d     = crc_q;
    rcv_d     = rcv_q;
    if (cmd_i.frame_start) begin
      cnt_d     = {{(CntW-1){1'b0}}, 1'b1};
      func_d    = rx_byte_i;
      len_d     = '0;
      command_d = 8'h00;
      crc_d     = crc_upd;
      rcv_d     = '0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_d = '0;
      end else if (cmd_i.hdr_byte || cmd_i.pay_byte || cmd_i.crc_byte || cmd_i.load_data) begin
        cnt_d = cnt_inc[CntW-1:0];
      end
      if (cmd_i.hdr_byte || cmd_i.pay_byte) begin
        crc_d = crc_upd;
      end
      if (cmd_i.hdr_byte) begin
        unique case (cnt_q[1:0])
          2'd0: func_d = rx_byte_i;
          2'd1: len_d[7:0] = rx_byte_i;
          2'd2: len_d[15:8] = rx_byte_i;
          2'd3: command_d = rx_byte_i;
          default: ;
        endcase
      end
      if (cmd_i.crc_byte) begin
        unique case (cnt_q[1:0])
          2'd0: rcv_d[7:0]   = rx_byte_i;
          2'd1: rcv_d[15:8]  = rx_byte_i;
          2'd2: rcv_d[23:16] = rx_byte_i;
          2'd3: rcv_d[31:24] = rx_byte_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      func_q    <= 8'h00;
      len_q     <= '0;
      command_q <= 8'h00;
      crc_q     <= CRC_PRESET;
      rcv_q     <= '0;
    end else begin
      cnt_q     <= cnt_d;
      func_q    <= func_d;
      len_q     <= len_d;
      command_q <= command_d;
      crc_q     <= crc_d;
      rcv_q     <= rcv_d;
    end
  end

  // The read address runs one beat ahead of the result register during a burst.
  always_comb begin
    priority if (cmd_i.cnt_clr) rd_addr = '0;
    else if (cmd_i.load_data)   rd_addr = cnt_q[AW-1:0] + AW'(1);
    else                        rd_addr = cnt_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_byte && (cnt_q < CntW'(PAYLOAD_MAX))) begin
      mem[cnt_q[AW-1:0]] <= rx_byte_i;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_vld_d = (cmd_i.load_err || cmd_i.load_cmd || cmd_i.load_data) ||
                     (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      out_status_q <= cmd_i.err_code;
      out_byte_q   <= 8'h00;
      out_iscmd_q  <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.load_cmd) begin
      out_status_q <= STAT_OK;
      out_byte_q   <= command_q;
      out_iscmd_q  <= 1'b1;
      out_last_q   <= sts_o.len_zero;
    end else if (cmd_i.load_data) begin
      out_status_q <= STAT_OK;
      out_byte_q   <= rd_q;
      out_iscmd_q  <= 1'b0;
      out_last_q   <= sts_o.emit_last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = out_status_q;
  assign out_byte_o   = out_byte_q;
  assign is_command_o = out_iscmd_q;
  assign last_o       = out_last_q;

endmodule

### rtl/crc_checked_frame_receiver.sv
// A received byte is taken whenever the result register is free; a verdict or command
// beat is valid the cycle after the last CRC byte is taken.
// Throughput: one byte per cycle; a good frame with N payload bytes issues N+1 result
// beats, one per cycle while the output is free; input is stalled for the N payload
// beats (payload memory read port) and while the result register holds a stalled beat.
// Reset: asynchronous, active low; control, header and CRC state are cleared, the
// payload memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module crc_checked_frame_receiver import ccfr_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic        is_command_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0] exp_len_q;
  logic [7:0] wfc_q;
  logic       cfg_wr;
  ccfr_cmd_t  cmd;
  ccfr_sts_t  sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= 6'd8;
      wfc_q     <= 8'h00;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_EXPECTED_LENGTH:     exp_len_q <= pwdata[5:0];
        REG_WRITE_FUNCTION_CODE: wfc_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXPECTED_LENGTH:     prdata = {26'h0, exp_len_q};
      REG_WRITE_FUNCTION_CODE: prdata = {24'h0, wfc_q};
      default:                 prdata = '0;
    endcase
  end

  ccfr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .frame_start_i (frame_start_i),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ccfr_dp #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .rx_byte_i             (rx_byte_i),
    .expected_length_i     (exp_len_q),
    .write_function_code_i (wfc_q),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .out_byte_o            (out_byte_o),
    .is_command_o          (is_command_o),
    .last_o                (last_o)
  );

endmodule
